FILE: rtl/brir_pkg.sv
// Package for the bilinear image resampler: field widths, register codes,
// fixed-point widths and the multiply-accumulate control word.
// Depends on nothing; every other file imports it.
`default_nettype none

package brir_pkg;

   localparam int SRC_W  = 7;   // src_width / src_height register width
   localparam int DST_W  = 9;   // dst_width / dst_height register width
   localparam int COORD_W = 8;  // col / row field width
   localparam int CHAN_W = 2;
   localparam int SMP_W  = 16;
   localparam int FRAC_W = 16;
   localparam int PROD_W = COORD_W + SRC_W;        // d * (s - 1)
   localparam int QUOT_W = PROD_W + FRAC_W;        // source position
   localparam int FWT_W  = FRAC_W + 1;             // 65536 - f
   localparam int WGT_W  = 2 * FWT_W - 1;          // product of two weights
   localparam int ACC_W  = WGT_W + SMP_W;          // blended sum
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_WIDTH  = 2'd2,
      REG_DST_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic {
      MODE_STORE   = 1'b0,
      MODE_REQUEST = 1'b1
   } mode_type;

   typedef struct packed {
      logic       load;       // take new weights, clear the sum
      logic       smp_valid;  // a neighbour word is on the read data
      logic [1:0] idx;        // which neighbour
   } mac_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/brir_divider.sv
// Restoring divider, one quotient bit a cycle, for the coordinate mapping.
// Depends on brir_pkg for the quotient and divisor widths.
`default_nettype none

module brir_divider
   import brir_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [QUOT_W-1:0] numer,
   input  wire logic [DST_W-1:0]  denom,
   output logic                   busy,
   output logic [QUOT_W-1:0]      quot
);

   localparam int CNT_W = $clog2(QUOT_W);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [QUOT_W-1:0] num_ff, num_in;
   logic [DST_W-1:0]  rem_ff, rem_in;
   logic [DST_W-1:0]  den_ff, den_in;
   logic [DST_W:0]    trial;
   logic [DST_W:0]    diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, num_ff[QUOT_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         num_in = {num_ff[QUOT_W-2:0], ge};
         rem_in = ge ? diff[DST_W-1:0] : trial[DST_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

FILE: rtl/brir_plane.sv
// Source plane store: single-port synchronous memory with a registered read.
// Depends on brir_pkg for the sample width.
`default_nettype none

module brir_plane
   import brir_pkg::*;
#(
   parameter int AW    = 14,
   parameter int DEPTH = 12288
)
(
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic             re,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [SMP_W-1:0] wdata,
   output logic [SMP_W-1:0]      rdata
);

   logic [SMP_W-1:0] mem [DEPTH];
   logic [SMP_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/brir_blend.sv
// Bilinear blend: four corner weights, one multiply-accumulate per neighbour
// word, round to nearest. Depends on brir_pkg for widths and mac_ctl_type.
`default_nettype none

module brir_blend
   import brir_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mac_ctl_type       ctl,
   input  wire logic [FRAC_W-1:0] fx,
   input  wire logic [FRAC_W-1:0] fy,
   input  wire logic [SMP_W-1:0]  smp,
   output logic                   mac_busy,
   output logic [SMP_W-1:0]       result
);

   localparam logic [FWT_W-1:0] ONE = FWT_W'(1) << FRAC_W;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (2 * FRAC_W - 1);

   logic [WGT_W-1:0]          w_ff [4];
   logic [WGT_W-1:0]          w_in [4];
   logic [FWT_W-1:0]          wx0, wx1, wy0, wy1;
   logic signed [WGT_W+SMP_W:0] mult_full;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic                      prod_vld_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]          rnd;

   always_comb begin
      wx0 = ONE - FWT_W'(fx);
      wx1 = FWT_W'(fx);
      wy0 = ONE - FWT_W'(fy);
      wy1 = FWT_W'(fy);
      w_in[0] = WGT_W'(wx0 * wy0);
      w_in[1] = WGT_W'(wx1 * wy0);
      w_in[2] = WGT_W'(wx0 * wy1);
      w_in[3] = WGT_W'(wx1 * wy1);
      mult_full = $signed({1'b0, w_ff[ctl.idx]}) * $signed(smp);
      prod_in   = mult_full[ACC_W-1:0];
      acc_in    = acc_ff;
      if (ctl.load) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
      rnd = acc_ff + HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.smp_valid;
      end
      if (ctl.load) begin
         for (int k = 0; k < 4; k++) begin
            w_ff[k] <= w_in[k];
         end
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mac_busy = prod_vld_ff;
   assign result   = rnd[2*FRAC_W +: SMP_W];

endmodule

`default_nettype wire

FILE: rtl/bilinear_image_resampler_top.sv
// Channel     | direction | words
// req         | in        | mode, col, row, chan, sample
// rsp         | out       | result_sample
// apb (psel)  | in/out    | src_width, src_height, dst_width, dst_height
// A store is written in the cycle it is accepted. A request holds req stalled through
// the serial coordinate divider, the weight load, four reads of the single-port source
// plane and the accumulate drain; its word is then registered into rsp.
// An absent channel skips those steps, holds req stalled and gives a zero result word.
// Reset is synchronous; the plane is not cleared. The rsp register holds a word
// while rsp_stall is high; a finished request then waits and req stays stalled.
// Depends on brir_pkg, brir_divider, brir_plane and brir_blend.
`default_nettype none

module bilinear_image_resampler_top
   import brir_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 64,
   parameter int MAX_SRC_HEIGHT = 64,
   parameter int NUM_CHANNELS   = 3
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mode,
   input  wire logic [COORD_W-1:0] req_col,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic [CHAN_W-1:0]  req_chan,
   input  wire logic signed [SMP_W-1:0] req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [SMP_W-1:0] rsp_result_sample,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [CSR_AW-1:0]  paddr,
   input  wire logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]       prdata,
   output logic                    pready
);

   localparam int CW    = $clog2(MAX_SRC_WIDTH);
   localparam int RW    = $clog2(MAX_SRC_HEIGHT);
   localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int AW    = CHW + RW + CW;
   localparam int DEPTH = NUM_CHANNELS << (RW + CW);
   localparam int IW    = PROD_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_WGT   = 6'b000100,
      ST_RD    = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [SRC_W-1:0] src_width_ff, src_height_ff;
   logic [DST_W-1:0] dst_width_ff, dst_height_ff;
   logic [SRC_W-1:0] sw, sh, sw_m1, sh_m1;
   logic             dx_zero, dy_zero;
   logic             cfg_we;
   reg_index_type    cfg_idx;

   logic             req_acc, store_we, req_start;
   logic             chan_ok, store_ok;
   logic [CHW-1:0]   ch_ff, ch_in;
   logic             zero_ff, zero_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             rd_pend_ff;
   logic [1:0]       rd_idx_ff;
   logic [CW-1:0]    x0_ff, x1_ff;
   logic [RW-1:0]    y0_ff, y1_ff;
   logic [CW-1:0]    x0_in, x1_in;
   logic [RW-1:0]    y0_in, y1_in;

   logic [PROD_W-1:0] prodx, prody;
   logic              divx_busy, divy_busy;
   logic [QUOT_W-1:0] qx, qy, px, py;
   logic [IW-1:0]     ix, iy;
   logic [IW:0]       ix1, iy1;

   logic              plane_re;
   logic [AW-1:0]     plane_addr;
   logic [SMP_W-1:0]  plane_rdata;
   mac_ctl_type       mac_ctl;
   logic              mac_busy;
   logic [SMP_W-1:0]  blend_result;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              out_free;

   // configuration
   assign pready  = 1'b1;
   assign cfg_we  = psel & penable & pwrite;
   assign cfg_idx = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_W'(64);
         src_height_ff <= SRC_W'(64);
         dst_width_ff  <= DST_W'(128);
         dst_height_ff <= DST_W'(128);
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_SRC_WIDTH:  src_width_ff  <= pwdata[SRC_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= pwdata[SRC_W-1:0];
            REG_DST_WIDTH:  dst_width_ff  <= pwdata[DST_W-1:0];
            REG_DST_HEIGHT: dst_height_ff <= pwdata[DST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_SRC_WIDTH:  prdata = CSR_DW'(src_width_ff);
         REG_SRC_HEIGHT: prdata = CSR_DW'(src_height_ff);
         REG_DST_WIDTH:  prdata = CSR_DW'(dst_width_ff);
         REG_DST_HEIGHT: prdata = CSR_DW'(dst_height_ff);
         default:        prdata = '0;
      endcase
   end

   // effective sizes
   always_comb begin
      sw = src_width_ff;
      if (src_width_ff == '0) begin
         sw = SRC_W'(1);
      end else if (32'(src_width_ff) > MAX_SRC_WIDTH) begin
         sw = SRC_W'(MAX_SRC_WIDTH);
      end
      sh = src_height_ff;
      if (src_height_ff == '0) begin
         sh = SRC_W'(1);
      end else if (32'(src_height_ff) > MAX_SRC_HEIGHT) begin
         sh = SRC_W'(MAX_SRC_HEIGHT);
      end
      sw_m1   = sw - 1'b1;
      sh_m1   = sh - 1'b1;
      dx_zero = dst_width_ff <= DST_W'(1);
      dy_zero = dst_height_ff <= DST_W'(1);
   end

   // request decode
   assign req_stall = state_ff != ST_IDLE;
   assign req_acc   = req_valid & ~req_stall;
   assign chan_ok   = 32'(req_chan) < NUM_CHANNELS;
   assign store_ok  = chan_ok && (32'(req_col) < MAX_SRC_WIDTH)
                      && (32'(req_row) < MAX_SRC_HEIGHT);
   assign store_we  = req_acc && (mode_type'(req_mode) == MODE_STORE) && store_ok;
   assign req_start = req_acc && (mode_type'(req_mode) == MODE_REQUEST) && chan_ok;
   assign prodx     = PROD_W'(req_col * sw_m1);
   assign prody     = PROD_W'(req_row * sh_m1);

   brir_divider u_divx (
      .clock (clock),
      .reset (reset),
      .start (req_start),
      .numer ({prodx, {FRAC_W{1'b0}}}),
      .denom (dst_width_ff - 1'b1),
      .busy  (divx_busy),
      .quot  (qx)
   );

   brir_divider u_divy (
      .clock (clock),
      .reset (reset),
      .start (req_start),
      .numer ({prody, {FRAC_W{1'b0}}}),
      .denom (dst_height_ff - 1'b1),
      .busy  (divy_busy),
      .quot  (qy)
   );

   // neighbour positions, clamped to the source edges
   always_comb begin
      px  = dx_zero ? '0 : qx;
      py  = dy_zero ? '0 : qy;
      ix  = px[QUOT_W-1:FRAC_W];
      iy  = py[QUOT_W-1:FRAC_W];
      ix1 = {1'b0, ix} + 1'b1;
      iy1 = {1'b0, iy} + 1'b1;
      x0_in = (ix  > IW'(sw_m1))       ? CW'(sw_m1) : CW'(ix);
      x1_in = (ix1 > (IW + 1)'(sw_m1)) ? CW'(sw_m1) : CW'(ix1);
      y0_in = (iy  > IW'(sh_m1))       ? RW'(sh_m1) : RW'(iy);
      y1_in = (iy1 > (IW + 1)'(sh_m1)) ? RW'(sh_m1) : RW'(iy1);
   end

   // sequencer
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ch_in    = ch_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (mode_type'(req_mode) == MODE_REQUEST)) begin
               ch_in   = CHW'(req_chan);
               zero_in = ~chan_ok;
               state_in = chan_ok ? ST_DIV : ST_FIN;
            end
         end
         ST_DIV: begin
            if (!divx_busy && !divy_busy) begin
               state_in = ST_WGT;
            end
         end
         ST_WGT: begin
            cnt_in   = '0;
            state_in = ST_RD;
         end
         ST_RD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_pend_ff && !mac_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         zero_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= plane_re;
         zero_ff    <= zero_in;
      end
      rd_idx_ff <= cnt_ff;
      ch_ff     <= ch_in;
      if (state_ff == ST_WGT) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y0_ff <= y0_in;
         y1_ff <= y1_in;
      end
   end

   // plane access: store from the port, neighbour reads in order
   assign plane_re = state_ff == ST_RD;

   always_comb begin
      if (state_ff == ST_RD) begin
         plane_addr = {ch_ff, cnt_ff[1] ? y1_ff : y0_ff, cnt_ff[0] ? x1_ff : x0_ff};
      end else begin
         plane_addr = {CHW'(req_chan), RW'(req_row), CW'(req_col)};
      end
   end

   brir_plane #(
      .AW    (AW),
      .DEPTH (DEPTH)
   ) u_plane (
      .clock (clock),
      .we    (store_we),
      .re    (plane_re),
      .addr  (plane_addr),
      .wdata (req_sample),
      .rdata (plane_rdata)
   );

   always_comb begin
      mac_ctl.load      = state_ff == ST_WGT;
      mac_ctl.smp_valid = rd_pend_ff;
      mac_ctl.idx       = rd_idx_ff;
   end

   brir_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .fx       (px[FRAC_W-1:0]),
      .fy       (py[FRAC_W-1:0]),
      .smp      (plane_rdata),
      .mac_busy (mac_busy),
      .result   (blend_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_FIN && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = zero_ff ? '0 : blend_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_sample = rsp_data_ff;

`ifndef SYNTHESIS
   a_store_no_read: assert property (@(posedge clock) disable iff (reset)
      store_we |-> !rd_pend_ff)
      else $error("plane write while a read is outstanding");

   a_store_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (store_we && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("store produced a result word");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WGT) |-> (!divx_busy && !divy_busy))
      else $error("weights taken before the divide finished");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FIN))
      else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire
